/* rtl/mfr_pkg.sv */
// Shared constants and controller/datapath interface types for the meter frame receiver.
package mfr_pkg;

    localparam int BUF_BYTES_DEF    = 64;
    localparam int BYTE_W           = 8;
    localparam int INDEX_W          = 6;
    localparam int START_MARK       = 8'h68;
    localparam int END_MARK         = 8'h16;
    localparam int END_OFFSET       = 11;
    localparam int SECOND_START_POS = 7;
    localparam int LENGTH_POS       = 9;
    localparam int SUM_W            = 9;

    typedef struct packed {
        logic take_byte;
        logic read_byte;
        logic next_byte;
    } cmd_t;

    typedef struct packed {
        logic frame_done;
        logic rd_last;
    } status_t;

endpackage

/* rtl/mfr_ctrl.sv */
// Controller state machine: receive, buffer read and result transfer sequencing.
module mfr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  mfr_pkg::status_t status,
    output mfr_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SHOW = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.read_byte = 1'b0;
        cmd.next_byte = 1'b0;
        unique case (state_reg)
            ST_RECV: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
                if (s_valid && status.frame_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_byte = 1'b1;
                state_next    = ST_SHOW;
            end
            ST_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    // advance to the next stored byte unless this transfer ends the frame
                    if (status.rd_last) begin
                        state_next = ST_RECV;
                    end else begin
                        cmd.next_byte = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

/* rtl/mfr_datapath.sv */
// Datapath: frame parsing registers, frame buffer and replay read pointer.
module mfr_datapath #(
    parameter int BUF_BYTES = mfr_pkg::BUF_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mfr_pkg::BYTE_W-1:0]    s_rx_byte,
    input  mfr_pkg::cmd_t                 cmd,
    output mfr_pkg::status_t              status,
    output logic [mfr_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic [mfr_pkg::INDEX_W-1:0]   m_byte_index,
    output logic                          m_last_of_frame
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int CNT_W  = $clog2(BUF_BYTES + 1);

    logic                         collecting_reg, collecting_next;
    logic [CNT_W-1:0]             byte_count_reg, byte_count_next;
    logic                         second_start_ok_reg, second_start_ok_next;
    logic [mfr_pkg::BYTE_W-1:0]   length_field_reg, length_field_next;
    logic [ADDR_W-1:0]            rd_idx_reg;
    logic [ADDR_W-1:0]            rd_end_reg;
    logic [mfr_pkg::BYTE_W-1:0]   rd_data_reg;
    logic [mfr_pkg::BYTE_W-1:0]   frame_mem [BUF_BYTES];

    logic                         start_seen;
    logic                         active;
    logic [CNT_W-1:0]             idx;
    logic                         overflow;
    logic                         store_byte;
    logic [mfr_pkg::SUM_W-1:0]    end_pos;
    logic                         done;

    always_comb begin
        start_seen = !collecting_reg && (s_rx_byte == mfr_pkg::BYTE_W'(mfr_pkg::START_MARK));
        active     = collecting_reg || start_seen;
        idx        = collecting_reg ? byte_count_reg : '0;
        overflow   = (idx >= CNT_W'(BUF_BYTES));
        store_byte = cmd.take_byte && active && !overflow;
        end_pos    = mfr_pkg::SUM_W'(length_field_reg) + mfr_pkg::SUM_W'(mfr_pkg::END_OFFSET);
        done       = active && !overflow && second_start_ok_reg
                     && (idx > CNT_W'(mfr_pkg::LENGTH_POS))
                     && (mfr_pkg::SUM_W'(idx) == end_pos)
                     && (s_rx_byte == mfr_pkg::BYTE_W'(mfr_pkg::END_MARK));
        status.frame_done = done;
        status.rd_last    = (rd_idx_reg == rd_end_reg);
    end

    always_comb begin
        collecting_next      = collecting_reg;
        byte_count_next      = byte_count_reg;
        second_start_ok_next = second_start_ok_reg;
        length_field_next    = length_field_reg;
        if (cmd.take_byte && active) begin
            if (overflow || done) begin
                // drop or finish: back to hunting
                collecting_next      = 1'b0;
                byte_count_next      = '0;
                second_start_ok_next = 1'b0;
                length_field_next    = '0;
            end else begin
                collecting_next = 1'b1;
                byte_count_next = idx + CNT_W'(1);
                if (start_seen) begin
                    second_start_ok_next = 1'b0;
                    length_field_next    = '0;
                end
                if (idx == CNT_W'(mfr_pkg::SECOND_START_POS)) begin
                    second_start_ok_next =
                        (s_rx_byte == mfr_pkg::BYTE_W'(mfr_pkg::START_MARK));
                end
                if (idx == CNT_W'(mfr_pkg::LENGTH_POS)) begin
                    length_field_next = s_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg      <= 1'b0;
            byte_count_reg      <= '0;
            second_start_ok_reg <= 1'b0;
            length_field_reg    <= '0;
            rd_idx_reg          <= '0;
        end else begin
            collecting_reg      <= collecting_next;
            byte_count_reg      <= byte_count_next;
            second_start_ok_reg <= second_start_ok_next;
            length_field_reg    <= length_field_next;
            if (cmd.take_byte && done) begin
                rd_idx_reg <= '0;
            end else if (cmd.next_byte) begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte && done) begin
            rd_end_reg <= idx[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (store_byte) begin
            frame_mem[idx[ADDR_W-1:0]] <= s_rx_byte;
        end
        if (cmd.read_byte) begin
            rd_data_reg <= frame_mem[rd_idx_reg];
        end
    end

    assign m_frame_byte    = rd_data_reg;
    assign m_byte_index    = mfr_pkg::INDEX_W'(rd_idx_reg);
    assign m_last_of_frame = (rd_idx_reg == rd_end_reg);

endmodule

/* rtl/meter_frame_receiver.sv */
// Frame bytes go into the frame buffer one per cycle while receiving, at most one
// transfer per clock. A complete frame is replayed from the buffer: the first result
// is valid after the end byte transfer and a buffer read, and each frame byte takes
// a buffer read, then a result transfer, plus any output stall. No input is taken
// during replay. Synchronous active-low reset clears the controller and parse state;
// the frame buffer is not cleared: only bytes of the current frame are ever read back.
module meter_frame_receiver #(
    parameter int BUF_BYTES = mfr_pkg::BUF_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mfr_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mfr_pkg::BYTE_W-1:0]    m_frame_byte,
    output logic [mfr_pkg::INDEX_W-1:0]   m_byte_index,
    output logic                          m_last_of_frame
);

    mfr_pkg::cmd_t    cmd;
    mfr_pkg::status_t status;

    mfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mfr_datapath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_rx_byte       (s_rx_byte),
        .cmd             (cmd),
        .status          (status),
        .m_frame_byte    (m_frame_byte),
        .m_byte_index    (m_byte_index),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
